FILE: hw/rtl/sapr_pkg.sv
// ----------------------------------------------------------------------------
// sapr_pkg
// Shared types and constants for the shaded annulus pixel rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none
package sapr_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 200;
    localparam int ROW_PITCH_DEF     = 320;

    localparam int SHADE_MAX   = 63;
    localparam int TINT_SCALE  = 256;

    // Root of a 22-bit radicand: 11 result bits, one per cell.
    localparam int ROOT_W = 11;
    localparam int RAD_W  = 2 * ROOT_W;

    // Division of a 17-bit magnitude by a 12-bit divisor, one bit per cell.
    localparam int NUM_W = 17;
    localparam int DEN_W = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_INNER_RADIUS = 3'd2,
        REG_OUTER_RADIUS = 3'd3,
        REG_SHADE_INNER  = 3'd4,
        REG_SHADE_OUTER  = 3'd5,
        REG_TINT_COLOUR  = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
    } t_in_item;

    typedef struct packed {
        logic        covered;
        logic [5:0]  shade_level;
        logic [13:0] fade_index;
        logic [19:0] pixel_offset;
    } t_out_item;

    // Side data that rides along the square root chain.
    typedef struct packed {
        logic               live;
        logic        [9:0]  px;
        logic        [19:0] offset;
        logic               row_ok;
        logic               hole;
        logic signed [13:0] cx;
        logic        [5:0]  si;
        logic        [5:0]  so;
        logic        [7:0]  tint;
    } t_row_info;

    // Side data that rides along the divider chain.
    typedef struct packed {
        logic        live;
        logic        covered;
        logic        neg;
        logic [5:0]  base;
        logic [7:0]  tint;
        logic [19:0] offset;
    } t_div_info;

endpackage
`default_nettype wire

FILE: hw/rtl/sapr_sqrt_cell.sv
// ----------------------------------------------------------------------------
// sapr_sqrt_cell
// One restoring square root step for two radicands side by side.
// ----------------------------------------------------------------------------
`default_nettype none
module sapr_sqrt_cell
    import sapr_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [RAD_W-1:0]  i_rem_o,
    input  wire logic [ROOT_W-1:0] i_root_o,
    input  wire logic [RAD_W-1:0]  i_rem_i,
    input  wire logic [ROOT_W-1:0] i_root_i,
    input  wire t_row_info         i_info,
    output logic      [RAD_W-1:0]  o_rem_o,
    output logic      [ROOT_W-1:0] o_root_o,
    output logic      [RAD_W-1:0]  o_rem_i,
    output logic      [ROOT_W-1:0] o_root_i,
    output t_row_info              o_info
);
    localparam int BIT = ROOT_W - 1 - STEP;

    logic [RAD_W-1:0]  n_rem_o, n_rem_i;
    logic [ROOT_W-1:0] n_root_o, n_root_i;

    function automatic logic [RAD_W+ROOT_W-1:0] step_f(
        input logic [RAD_W-1:0] rem, input logic [ROOT_W-1:0] root);
        logic [RAD_W:0]    trial;
        logic [RAD_W-1:0]  r;
        logic [ROOT_W-1:0] q;
        trial = {1'b0, {(RAD_W-ROOT_W){1'b0}}, root} << (BIT + 1);
        trial = trial | ({{RAD_W{1'b0}}, 1'b1} << (2 * BIT));
        r = rem;
        q = root;
        if ({1'b0, rem} >= trial) begin
            r = rem - trial[RAD_W-1:0];
            q[BIT] = 1'b1;
        end
        return {r, q};
    endfunction

    always_comb begin
        {n_rem_o, n_root_o} = step_f(i_rem_o, i_root_o);
        {n_rem_i, n_root_i} = step_f(i_rem_i, i_root_i);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_info.live <= 1'b0;
        end else if (i_en) begin
            o_info.live <= i_info.live;
        end
        if (i_en) begin
            o_rem_o         <= n_rem_o;
            o_root_o        <= n_root_o;
            o_rem_i         <= n_rem_i;
            o_root_i        <= n_root_i;
            o_info.px       <= i_info.px;
            o_info.offset   <= i_info.offset;
            o_info.row_ok   <= i_info.row_ok;
            o_info.hole     <= i_info.hole;
            o_info.cx       <= i_info.cx;
            o_info.si       <= i_info.si;
            o_info.so       <= i_info.so;
            o_info.tint     <= i_info.tint;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/sapr_div_cell.sv
// ----------------------------------------------------------------------------
// sapr_div_cell
// One restoring division step: produces one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none
module sapr_div_cell
    import sapr_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_rem,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire t_div_info         i_info,
    output logic      [NUM_W-1:0]  o_num,
    output logic      [DEN_W-1:0]  o_rem,
    output logic      [DEN_W-1:0]  o_den,
    output t_div_info              o_info
);
    localparam int BIT = NUM_W - 1 - STEP;

    logic [DEN_W:0]    trial;
    logic [DEN_W-1:0]  n_rem;
    logic [NUM_W-1:0]  n_num;

    always_comb begin
        trial = {i_rem, i_num[BIT]};
        n_num = i_num;
        if (trial >= {1'b0, i_den}) begin
            n_rem      = DEN_W'(trial - {1'b0, i_den});
            n_num[BIT] = 1'b1;
        end else begin
            n_rem      = trial[DEN_W-1:0];
            n_num[BIT] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_info.live <= 1'b0;
        end else if (i_en) begin
            o_info.live <= i_info.live;
        end
        if (i_en) begin
            o_num          <= n_num;
            o_rem          <= n_rem;
            o_den          <= i_den;
            o_info.covered <= i_info.covered;
            o_info.neg     <= i_info.neg;
            o_info.base    <= i_info.base;
            o_info.tint    <= i_info.tint;
            o_info.offset  <= i_info.offset;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/shaded_annulus_pixel_rasterizer_top.sv
// ----------------------------------------------------------------------------
// shaded_annulus_pixel_rasterizer_top
// Decides ring coverage and shade for one pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// One item is accepted every clock while the output is not stalled; each item
// passes through three setup stages, an 11-cell square root chain, two span
// stages, a 17-cell divider chain and an output stage.
// The whole pipe advances together, so a stall at the output holds every
// stage. Registers may be written only while the pipe is empty.
`default_nettype none
module shaded_annulus_pixel_rasterizer_top
    import sapr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int ROW_PITCH     = ROW_PITCH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_in_item              i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_out_item                  o_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int LAST_X = SCREEN_WIDTH - 1;

    logic signed [12:0] r_cx, r_cy;
    logic        [10:0] r_ir, r_or;
    logic        [5:0]  r_si, r_so;
    logic        [7:0]  r_tint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0; r_ir <= '0; r_or <= '0;
            r_si <= '0; r_so <= '0; r_tint <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_CENTER_X:     r_cx   <= i_cfg_data;
                REG_CENTER_Y:     r_cy   <= i_cfg_data;
                REG_INNER_RADIUS: r_ir   <= i_cfg_data[10:0];
                REG_OUTER_RADIUS: r_or   <= i_cfg_data[10:0];
                REG_SHADE_INNER:  r_si   <= i_cfg_data[5:0];
                REG_SHADE_OUTER:  r_so   <= i_cfg_data[5:0];
                REG_TINT_COLOUR:  r_tint <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Stage A: dy and offset product.
    logic              r_a_live, r_a_ok;
    logic        [9:0] r_a_px;
    logic signed [13:0] r_a_dy;
    logic        [19:0] r_a_off;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_live <= 1'b0;
        else if (en)  r_a_live <= i_valid;
        if (en) begin
            r_a_px  <= i_data.pixel_x;
            r_a_dy  <= $signed({4'b0, i_data.pixel_y}) - 14'(r_cy);
            r_a_off <= 20'(32'(i_data.pixel_y) * 32'(ROW_PITCH)
                           + 32'(i_data.pixel_x));
            r_a_ok  <= (r_or != '0) && (r_ir < r_or)
                       && (32'(i_data.pixel_x) < 32'(SCREEN_WIDTH))
                       && (32'(i_data.pixel_y) < 32'(SCREEN_HEIGHT));
        end
    end

    // Stage B: squares.
    logic        r_b_live, r_b_ok;
    logic [9:0]  r_b_px;
    logic [19:0] r_b_off;
    logic [27:0] r_b_dy2;
    logic [21:0] r_b_osq, r_b_isq;
    logic [13:0] dy_abs;
    assign dy_abs = r_a_dy[13] ? 14'(-r_a_dy) : r_a_dy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_live <= 1'b0;
        else if (en)  r_b_live <= r_a_live;
        if (en) begin
            r_b_px  <= r_a_px;
            r_b_off <= r_a_off;
            r_b_ok  <= r_a_ok;
            r_b_dy2 <= dy_abs * dy_abs;
            r_b_osq <= r_or * r_or;
            r_b_isq <= r_ir * r_ir;
        end
    end

    // Stage C: radicands.
    t_row_info        c_info;
    logic [RAD_W-1:0] r_c_rad_o, r_c_rad_i;
    logic             row_in, hole;
    assign row_in = r_b_dy2 <= 28'(r_b_osq);
    assign hole   = r_b_dy2 < 28'(r_b_isq);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) c_info.live <= 1'b0;
        else if (en)  c_info.live <= r_b_live;
        if (en) begin
            c_info.px     <= r_b_px;
            c_info.offset <= r_b_off;
            c_info.row_ok <= r_b_ok && row_in;
            c_info.hole   <= hole;
            c_info.cx     <= 14'(r_cx);
            c_info.si     <= r_si;
            c_info.so     <= r_so;
            c_info.tint   <= r_tint;
            r_c_rad_o     <= row_in ? 22'(28'(r_b_osq) - r_b_dy2) : '0;
            r_c_rad_i     <= hole   ? 22'(28'(r_b_isq) - r_b_dy2) : '0;
        end
    end

    // Square root chain.
    logic      [RAD_W-1:0]  rem_o [ROOT_W+1];
    logic      [RAD_W-1:0]  rem_i [ROOT_W+1];
    logic      [ROOT_W-1:0] root_o [ROOT_W+1];
    logic      [ROOT_W-1:0] root_i [ROOT_W+1];
    t_row_info              s_info [ROOT_W+1];
    assign rem_o[0]  = r_c_rad_o;
    assign rem_i[0]  = r_c_rad_i;
    assign root_o[0] = '0;
    assign root_i[0] = '0;
    assign s_info[0] = c_info;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        sapr_sqrt_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_rem_o (rem_o[g]),
            .i_root_o(root_o[g]),
            .i_rem_i (rem_i[g]),
            .i_root_i(root_i[g]),
            .i_info  (s_info[g]),
            .o_rem_o (rem_o[g+1]),
            .o_root_o(root_o[g+1]),
            .o_rem_i (rem_i[g+1]),
            .o_root_i(root_i[g+1]),
            .o_info  (s_info[g+1])
        );
    end

    // Stage D: span ends and clipping.
    t_row_info         d_in;
    logic signed [14:0] oh, ih, la, lb, ra, rb, lac, lbc, rac, rbc, x;
    logic signed [14:0] den;
    assign d_in = s_info[ROOT_W];
    assign oh = 15'(root_o[ROOT_W]);
    assign ih = 15'(root_i[ROOT_W]);
    assign x  = 15'(d_in.px);
    always_comb begin
        if (d_in.hole) begin
            la = 15'(d_in.cx) - oh;  lb = 15'(d_in.cx) - ih - 15'sd1;
            ra = 15'(d_in.cx) + ih + 15'sd1; rb = 15'(d_in.cx) + oh;
            den = oh - ih;
            if (den < 15'sd1) den = 15'sd1;
        end else begin
            la = 15'(d_in.cx) - oh;  lb = 15'(d_in.cx) - 15'sd1;
            ra = 15'(d_in.cx);       rb = 15'(d_in.cx) + oh;
            den = oh + 15'sd1;
        end
        lac = la < 0 ? 15'sd0 : la;
        rac = ra < 0 ? 15'sd0 : ra;
        lbc = lb > 15'(LAST_X) ? 15'(LAST_X) : lb;
        rbc = rb > 15'(LAST_X) ? 15'(LAST_X) : rb;
    end

    logic              r_d_live, r_d_ok, r_d_left, r_d_right;
    logic [10:0]       r_d_dl, r_d_dr;
    logic [DEN_W-1:0]  r_d_den;
    logic [5:0]        r_d_si, r_d_so;
    logic [7:0]        r_d_tint;
    logic [19:0]       r_d_off;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_live <= 1'b0;
        else if (en)  r_d_live <= d_in.live;
        if (en) begin
            r_d_ok    <= d_in.row_ok;
            r_d_left  <= (lbc >= lac) && (x >= lac) && (x <= lbc);
            r_d_right <= (rbc >= rac) && (x >= rac) && (x <= rbc);
            r_d_dl    <= 11'(x - lac);
            r_d_dr    <= 11'(x - rac);
            r_d_den   <= DEN_W'(den);
            r_d_si    <= d_in.si;
            r_d_so    <= d_in.so;
            r_d_tint  <= d_in.tint;
            r_d_off   <= d_in.offset;
        end
    end

    // Stage E: product delta*(x-a).
    logic signed [6:0]  delta;
    logic        [10:0] span_dx;
    logic        [6:0]  dabs;
    assign delta = r_d_left ? (7'(r_d_si) - 7'(r_d_so)) : (7'(r_d_so) - 7'(r_d_si));
    assign span_dx = r_d_left ? r_d_dl : r_d_dr;
    assign dabs  = delta[6] ? 7'(-delta) : delta;

    logic [NUM_W-1:0] r_e_num;
    logic [DEN_W-1:0] r_e_den;
    t_div_info        e_info;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) e_info.live <= 1'b0;
        else if (en)  e_info.live <= r_d_live;
        if (en) begin
            r_e_num        <= NUM_W'(dabs * span_dx);
            r_e_den        <= r_d_den;
            e_info.covered <= r_d_ok && (r_d_left || r_d_right);
            e_info.neg     <= delta[6];
            e_info.base    <= r_d_left ? r_d_so : r_d_si;
            e_info.tint    <= r_d_tint;
            e_info.offset  <= r_d_off;
        end
    end

    // Divider chain.
    logic      [NUM_W-1:0] q_num [NUM_W+1];
    logic      [DEN_W-1:0] q_rem [NUM_W+1];
    logic      [DEN_W-1:0] q_den [NUM_W+1];
    t_div_info             q_info [NUM_W+1];
    assign q_num[0]  = r_e_num;
    assign q_rem[0]  = '0;
    assign q_den[0]  = r_e_den;
    assign q_info[0] = e_info;

    for (genvar g = 0; g < NUM_W; g++) begin : g_div
        sapr_div_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_num  (q_num[g]),
            .i_rem  (q_rem[g]),
            .i_den  (q_den[g]),
            .i_info (q_info[g]),
            .o_num  (q_num[g+1]),
            .o_rem  (q_rem[g+1]),
            .o_den  (q_den[g+1]),
            .o_info (q_info[g+1])
        );
    end

    // Output stage: apply sign and clamp.
    t_div_info          f_in;
    logic signed [18:0] sh;
    logic        [5:0]  shc;
    assign f_in = q_info[NUM_W];
    always_comb begin
        sh = f_in.neg ? 19'(f_in.base) - 19'(q_num[NUM_W])
                      : 19'(f_in.base) + 19'(q_num[NUM_W]);
        if (sh < 0)                    shc = '0;
        else if (sh > 19'(SHADE_MAX))  shc = 6'(SHADE_MAX);
        else                           shc = sh[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (en)  o_valid <= f_in.live;
        if (en) begin
            o_data.covered      <= f_in.covered;
            o_data.shade_level  <= f_in.covered ? shc : '0;
            o_data.fade_index   <= f_in.covered
                                   ? 14'(shc * TINT_SCALE) + 14'(f_in.tint) : '0;
            o_data.pixel_offset <= f_in.offset;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/sapr_checker.sv
// ----------------------------------------------------------------------------
// sapr_checker
// Port-level checks for the shaded annulus pixel rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none
module sapr_checker
    import sapr_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_stall,
    input wire logic      o_valid,
    input wire logic      i_stall,
    input wire t_out_item o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("Stalled item changed.");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("Input stalled without output stall.");

    a_uncov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.covered |-> o_data.shade_level == '0
                                       && o_data.fade_index == '0)
        else $error("Uncovered item has a shade.");

    a_fade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.fade_index[13:8] == o_data.shade_level)
        else $error("Fade index does not match shade.");
endmodule

bind shaded_annulus_pixel_rasterizer_top sapr_checker u_sapr_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_data (o_data)
);
`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the annulus rasterizer against a shade predictor over many ring setups.
// ----------------------------------------------------------------------------
// Each phase writes the ring registers while the pipe is empty, then streams
// pixel items in random bursts. Every accepted item is predicted at once and
// queued, and every output item is compared with the oldest prediction.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import sapr_pkg::*;

    localparam int SW = 320;
    localparam int SH = 200;
    localparam int PITCH = 320;
    localparam int LATENCY = 34;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    t_in_item i_data = '0;
    logic o_valid;
    logic i_stall = 0;
    t_out_item o_data;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    shaded_annulus_pixel_rasterizer_top dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    longint ring_cx, ring_cy, ring_ir, ring_or, ring_si, ring_so, ring_tint;
    t_in_item pixel_queue[$];
    t_out_item expected_q[$];
    int errors = 0;
    bit feed_on = 0;
    bit hold_long = 0;

    function automatic longint isqrt(longint v);
        longint r;
        r = 0;
        if (v <= 0) return 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function automatic longint shade_in_span(longint x, longint a, longint b, longint base,
                                             longint delta, longint den);
        longint s;
        if (a < 0) a = 0;
        if (b > SW - 1) b = SW - 1;
        if (b < a || x < a || x > b) return -1;
        if (den < 1) den = 1;
        s = base + (delta * (x - a)) / den;
        if (s < 0) s = 0;
        if (s > 63) s = 63;
        return s;
    endfunction

    function automatic t_out_item predict_pixel(t_in_item it);
        t_out_item r;
        longint px, py, sh, osq, isq, dy2, oh, ih;
        px = it.pixel_x;
        py = it.pixel_y;
        sh = -1;
        if (ring_or > 0 && ring_ir < ring_or && px < SW && py < SH) begin
            osq = ring_or * ring_or;
            isq = ring_ir * ring_ir;
            dy2 = (py - ring_cy) * (py - ring_cy);
            if (dy2 <= osq) begin
                oh = isqrt(osq - dy2);
                if (dy2 < isq) begin
                    ih = isqrt(isq - dy2);
                    sh = shade_in_span(px, ring_cx - oh, ring_cx - ih - 1, ring_so,
                                       ring_si - ring_so, oh - ih);
                    if (sh < 0)
                        sh = shade_in_span(px, ring_cx + ih + 1, ring_cx + oh, ring_si,
                                           ring_so - ring_si, oh - ih);
                end else begin
                    sh = shade_in_span(px, ring_cx - oh, ring_cx - 1, ring_so,
                                       ring_si - ring_so, oh + 1);
                    if (sh < 0)
                        sh = shade_in_span(px, ring_cx, ring_cx + oh, ring_si,
                                           ring_so - ring_si, oh + 1);
                end
            end
        end
        r.covered = sh >= 0;
        r.shade_level = sh >= 0 ? 6'(sh) : 6'd0;
        r.fade_index = sh >= 0 ? 14'(sh * 256 + ring_tint) : 14'd0;
        r.pixel_offset = 20'(py * PITCH + px);
        return r;
    endfunction

    // Sender: bursts and gaps; a held item is never changed.
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) expected_q.push_back(predict_pixel(i_data));
            if (!i_valid || !o_stall) begin
                if (feed_on && pixel_queue.size() > 0 && gap_left == 0) begin
                    i_valid <= 1;
                    i_data <= pixel_queue.pop_front();
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 0;
                    if (gap_left > 0) gap_left--;
                end
            end
        end
    end

    // Receiver: stall pattern of its own plus an occasional long hold.
    int stall_mode = 0, mode_left = 0, hold_cnt = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected item %p", $time, o_data);
                    errors++;
                end else if (expected_q[0] !== o_data) begin
                    $display("%0t: mismatch expected %p actual %p", $time, expected_q[0],
                             o_data);
                    errors++;
                    void'(expected_q.pop_front());
                end else begin
                    void'(expected_q.pop_front());
                end
            end
            if (hold_long) begin
                hold_cnt++;
                if (hold_cnt > 150) begin
                    hold_long = 0;
                    hold_cnt = 0;
                end
                i_stall <= 1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 80);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0: i_stall <= 0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    default: i_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(t_cfg_reg idx, longint val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            REG_CENTER_X: ring_cx = longint'($signed(13'(val)));
            REG_CENTER_Y: ring_cy = longint'($signed(13'(val)));
            REG_INNER_RADIUS: ring_ir = val & 64'h7FF;
            REG_OUTER_RADIUS: ring_or = val & 64'h7FF;
            REG_SHADE_INNER: ring_si = val & 64'h3F;
            REG_SHADE_OUTER: ring_so = val & 64'h3F;
            REG_TINT_COLOUR: ring_tint = val & 64'hFF;
            default: ;
        endcase
    endtask

    task automatic setup_ring(longint cx, longint cy, longint ir, longint orr, longint si,
                              longint so, longint tint);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_INNER_RADIUS, ir);
        write_reg(REG_OUTER_RADIUS, orr);
        write_reg(REG_SHADE_INNER, si);
        write_reg(REG_SHADE_OUTER, so);
        write_reg(REG_TINT_COLOUR, tint);
    endtask

    task automatic add_pixel(int x, int y);
        t_in_item it;
        it.pixel_x = 10'(x);
        it.pixel_y = 10'(y);
        pixel_queue.push_back(it);
    endtask

    task automatic drain_pipe();
        feed_on = 1;
        wait (pixel_queue.size() == 0);
        @(posedge i_clk);
        while (i_valid || expected_q.size() > 0) @(posedge i_clk);
        feed_on = 0;
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic random_pixels(int n);
        int x, y;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) < 8) begin
                // Mostly near the ring so that spans and holes are exercised.
                x = int'(ring_cx) + $urandom_range(0, 2 * ring_or + 4) - int'(ring_or) - 2;
                y = int'(ring_cy) + $urandom_range(0, 2 * ring_or + 4) - int'(ring_or) - 2;
                if (x < 0 || x > 1023) x = $urandom_range(0, SW - 1);
                if (y < 0 || y > 1023) y = $urandom_range(0, SH - 1);
            end else begin
                x = $urandom_range(0, 1023);
                y = $urandom_range(0, 1023);
            end
            add_pixel(x, y);
        end
    endtask

    initial begin
        int cx, cy, ir, orr;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        ring_cx = 0; ring_cy = 0; ring_ir = 0; ring_or = 0;
        ring_si = 0; ring_so = 0; ring_tint = 0;
        // Reset ring is empty.
        add_pixel(0, 0); add_pixel(5, 5);
        drain_pipe();
        // Directed: disc, annulus, off-screen, extremes, empty rings.
        setup_ring(160, 100, 0, 50, 63, 0, 255);
        add_pixel(160, 100); add_pixel(110, 100); add_pixel(210, 100);
        add_pixel(159, 100); add_pixel(160, 50); add_pixel(160, 150);
        add_pixel(1023, 1023); add_pixel(320, 100); add_pixel(100, 200);
        add_pixel(319, 199); add_pixel(0, 0);
        drain_pipe();
        setup_ring(160, 100, 30, 60, 0, 63, 17);
        add_pixel(160, 100); add_pixel(129, 100); add_pixel(191, 100);
        add_pixel(100, 100); add_pixel(220, 100); add_pixel(160, 41);
        drain_pipe();
        setup_ring(-4096, 4095, 2047, 2047, 5, 9, 1);
        add_pixel(0, 0); add_pixel(10, 10);
        drain_pipe();
        setup_ring(4095, -4096, 0, 2047, 63, 63, 0);
        add_pixel(319, 0); add_pixel(0, 199);
        drain_pipe();
        setup_ring(-10, -10, 0, 2047, 0, 63, 128);
        add_pixel(0, 0); add_pixel(319, 199);
        drain_pipe();
        // Random phases, one with a long receiver hold.
        for (int ph = 0; ph < 16; ph++) begin
            cx = $urandom_range(0, 8191) - 4096;
            cy = $urandom_range(0, 8191) - 4096;
            if (ph % 3 != 0) begin
                cx = $urandom_range(0, 360) - 20;
                cy = $urandom_range(0, 240) - 20;
            end
            orr = (ph % 5 == 4) ? $urandom_range(0, 2047) : $urandom_range(0, 120);
            ir = (ph % 4 == 0) ? 0 : $urandom_range(0, orr + 2);
            setup_ring(cx, cy, ir, orr, $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 255));
            random_pixels(115);
            if (ph == 5) hold_long = 1;
            drain_pipe();
        end
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
